/* hw/rtl/hnbt_pkg.sv */
// ----------------------------------------------------------------------------
// hnbt_pkg: shared types and constants of the HDLC NRZI transmitter
// Line codes, CRC constants, sequencer states and the bit unit's structs.
// ----------------------------------------------------------------------------
package hnbt_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned RUN_W  = 3;
  localparam int unsigned CNT_W  = 4;

  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h8408;
  localparam logic [CRC_W-1:0]  CRC_PRESET  = 16'hFFFF;
  localparam logic [BYTE_W-1:0] FLAG_BYTE   = 8'h7E;
  localparam logic [BYTE_W-1:0] BYTE_MASK   = 8'hFF;
  localparam logic [RUN_W-1:0]  STUFF_LIMIT = 3'd5;

  // Index of the final line bit of a data byte and of the two FCS bytes.
  localparam logic [CNT_W-1:0] LAST_BIT_BYTE = 4'd7;
  localparam logic [CNT_W-1:0] LAST_BIT_FCS  = 4'd15;

  // Item modes.
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_FCS   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc;
    logic [RUN_W-1:0] run;
    logic             tone;
    logic             line_bit;
    logic             is_flag;
    logic             stuff_slot;
  } bit_req_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc;
    logic [RUN_W-1:0] run;
    logic             tone;
    logic             stuff_req;
  } bit_res_t;

endpackage

/* hw/rtl/hnbt_ifs.sv */
// ----------------------------------------------------------------------------
// hnbt_ifs: valid/ready channels of the HDLC NRZI transmitter
// One interface for input items and one for line bit results.
// ----------------------------------------------------------------------------
interface hnbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface hnbt_out_if;
  logic valid;
  logic ready;
  logic tone;
  logic stuffed;
  logic last;

  modport source (output valid, output tone, output stuffed, output last, input ready);
  modport sink (input valid, input tone, input stuffed, input last, output ready);
endinterface

/* hw/rtl/hnbt_bit_unit.sv */
// ----------------------------------------------------------------------------
// hnbt_bit_unit: one line bit period of the transmitter
// Clocks the reflected CRC-16, tracks the run of ones, flips the NRZI tone
// and asks for a stuffed zero after five ones.
// ----------------------------------------------------------------------------
module hnbt_bit_unit import hnbt_pkg::*; (
  input  bit_req_t req,
  output bit_res_t res
);

  logic [CRC_W-1:0] crc_shift;
  logic [CRC_W-1:0] crc_step;
  logic [RUN_W-1:0] run_base;
  logic [RUN_W-1:0] run_inc;

  assign crc_shift = {1'b0, req.crc[CRC_W-1:1]};
  assign crc_step  = (req.crc[0] ^ req.line_bit) ? (crc_shift ^ CRC_POLY) : crc_shift;
  // A flag clears the run before each of its bits, so it never stuffs.
  assign run_base  = req.is_flag ? '0 : req.run;
  assign run_inc   = run_base + RUN_W'(1);

  always_comb begin
    res = '0;
    if (req.stuff_slot) begin
      res.crc       = req.crc;
      res.run       = '0;
      res.tone      = ~req.tone;
      res.stuff_req = 1'b0;
    end else begin
      res.crc = req.is_flag ? req.crc : crc_step;
      if (!req.line_bit) begin
        res.tone      = ~req.tone;
        res.run       = '0;
        res.stuff_req = 1'b0;
      end else begin
        res.tone      = req.tone;
        res.run       = run_inc;
        res.stuff_req = (run_inc == STUFF_LIMIT);
      end
    end
  end

endmodule

/* hw/rtl/hdlc_nrzi_bit_stuffing_transmitter_unit.sv */
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_stuffing_transmitter_unit: AX.25 HDLC bit transmitter
// Sends frame bytes LSB first with CRC-16 (0x8408), zero stuffing and NRZI.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  items     in         valid/ready    mode[1:0], data_byte[7:0]
//  results   out        valid/ready    tone, stuffed, last
//
//  An item is taken only while the block is idle; the bit unit then produces
//  one line bit per cycle unless the results channel stalls: 8 to 10 for a
//  data byte, 8 for a flag, 16 to 20 for the FCS. The block takes no new item
//  until the final bit of the current one sits in the output register.
//  Start frame and the unused mode complete in the accepting cycle.
//  A stall on the results channel holds the bit unit. Reset presets the CRC.
// ----------------------------------------------------------------------------
module hdlc_nrzi_bit_stuffing_transmitter_unit import hnbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hnbt_in_if.sink     items,
  hnbt_out_if.source  results
);

  state_t            state;
  logic [CRC_W-1:0]  crc;
  logic [RUN_W-1:0]  run;
  logic              tone;
  logic [CRC_W-1:0]  shreg;
  logic [CNT_W-1:0]  bit_cnt;
  logic [CNT_W-1:0]  last_idx;
  logic              is_flag;
  logic              pend_stuff;

  logic              out_valid;
  logic              out_tone;
  logic              out_stuffed;
  logic              out_last;

  bit_req_t          breq;
  bit_res_t          bres;
  logic              accept;
  logic              step;
  logic              final_bit;
  logic              advance;

  assign items.ready     = (state == ST_IDLE);
  assign results.valid   = out_valid;
  assign results.tone    = out_tone;
  assign results.stuffed = out_stuffed;
  assign results.last    = out_last;

  assign accept    = items.valid && items.ready;
  assign step      = (state == ST_SEND) && (!out_valid || results.ready);
  assign final_bit = (bit_cnt == last_idx);

  always_comb begin
    breq.crc        = crc;
    breq.run        = run;
    breq.tone       = tone;
    breq.line_bit   = shreg[0];
    breq.is_flag    = is_flag;
    breq.stuff_slot = pend_stuff;
  end

  hnbt_bit_unit u_bit (
    .req (breq),
    .res (bres)
  );

  // A line bit moves on once its stuffed zero, if any, has gone out.
  assign advance = pend_stuff || !bres.stuff_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      crc        <= CRC_PRESET;
      run        <= '0;
      tone       <= 1'b0;
      pend_stuff <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (results.ready && !step) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (items.mode)
              MODE_START: begin
                crc <= CRC_PRESET;
                run <= '0;
              end
              MODE_DATA: begin
                shreg      <= {8'h00, items.data_byte};
                last_idx   <= LAST_BIT_BYTE;
                is_flag    <= (items.data_byte == FLAG_BYTE);
                bit_cnt    <= '0;
                pend_stuff <= 1'b0;
                state      <= ST_SEND;
              end
              MODE_FCS: begin
                shreg      <= {crc[15:8] ^ BYTE_MASK, crc[7:0] ^ BYTE_MASK};
                last_idx   <= LAST_BIT_FCS;
                is_flag    <= 1'b0;
                bit_cnt    <= '0;
                pend_stuff <= 1'b0;
                state      <= ST_SEND;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SEND: begin
          if (step) begin
            crc         <= bres.crc;
            run         <= bres.run;
            tone        <= bres.tone;
            out_valid   <= 1'b1;
            out_tone    <= bres.tone;
            out_stuffed <= pend_stuff;
            out_last    <= final_bit && advance;
            pend_stuff  <= !pend_stuff && bres.stuff_req;
            if (advance) begin
              shreg   <= {1'b0, shreg[CRC_W-1:1]};
              bit_cnt <= bit_cnt + CNT_W'(1);
              if (final_bit) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/hnbt_checker.sv */
// ----------------------------------------------------------------------------
// hnbt_checker: port-level checks of the HDLC NRZI transmitter
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hnbt_checker import hnbt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_tone,
  input logic       out_stuffed,
  input logic       out_last
);

  // A byte or FCS item keeps the block busy for at least its first bit.
  a_busy_after_send: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_DATA || in_mode == MODE_FCS) |=> !in_ready)
    else $error("block ready right after taking a byte or FCS item");

  // Start frame produces no bits and leaves the block ready.
  a_start_no_wait: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == MODE_START |=> in_ready && !(out_valid && !$past(out_valid)))
    else $error("start frame item stalled the block or produced a bit");

  // While a bit that is not the final one waits, the item is still in progress.
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("block ready while bits of the current item remain");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_tone) && $stable(out_stuffed)
      && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind hdlc_nrzi_bit_stuffing_transmitter_unit hnbt_checker u_hnbt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_mode     (items.mode),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_tone    (results.tone),
  .out_stuffed (results.stuffed),
  .out_last    (results.last)
);
